### hw/rtl/hkaf_pkg.sv
// hkaf_pkg: shared types and constants for the haptic knob angle and force block
// no dependencies; imported by haptic_knob_angle_and_force

package hkaf_pkg;

  // fixed field widths
  localparam int ANGLE_W = 26;
  localparam int SPEED_W = 27;
  localparam int LEVEL_W = 16;
  localparam int GAIN_W  = 20;
  localparam int SGAIN_W = 10;
  localparam int DB_W    = 10;
  localparam int THR_W   = 10;
  localparam int TURN_W  = 16;
  localparam int CFG_W   = 26;
  localparam int CFG_A_W = 3;

  // output request layout: on, dir, level, angle, speed, zero fill
  localparam int OUT_FIELDS_W = 2 + LEVEL_W + ANGLE_W + SPEED_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // fixed wall drive level
  localparam logic [LEVEL_W-1:0] WALL_DRIVE = 16'd1000;

  // register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_MODE            = 3'd0,
    REG_FLIP_THRESHOLD  = 3'd1,
    REG_ANGLE_DEAD_BAND = 3'd2,
    REG_SPEED_DEAD_BAND = 3'd3,
    REG_SPRING_GAIN     = 3'd4,
    REG_DAMPING_GAIN    = 3'd5,
    REG_TEXTURE_GAIN    = 3'd6,
    REG_WALL_POSITION   = 3'd7
  } reg_idx_t;

  // drive modes
  typedef enum logic [1:0] {
    MODE_SPRING  = 2'd0,
    MODE_DAMPER  = 2'd1,
    MODE_TEXTURE = 2'd2,
    MODE_WALL    = 2'd3
  } mode_t;

  // register reset values
  localparam logic [THR_W-1:0]   RST_FLIP_THRESHOLD  = 10'd500;
  localparam logic [DB_W-1:0]    RST_ANGLE_DEAD_BAND = 10'd102;
  localparam logic [DB_W-1:0]    RST_SPEED_DEAD_BAND = 10'd1;
  localparam logic [SGAIN_W-1:0] RST_SPRING_GAIN     = 10'd100;
  localparam logic [GAIN_W-1:0]  RST_DAMPING_GAIN    = 20'd100000;
  localparam logic [GAIN_W-1:0]  RST_TEXTURE_GAIN    = 20'd200000;
  localparam logic [ANGLE_W-1:0] RST_WALL_POSITION   = 26'd1024;

  // drive decision handed from the rule stage to the scaling stage
  typedef struct packed {
    logic on;
    logic dir;
    logic fixed;
  } drive_ctl_t;

endpackage

### hw/rtl/haptic_knob_angle_and_force.sv
// haptic_knob_angle_and_force: multi-turn angle unwrap and force-feedback drive
// depends on hkaf_pkg

// Takes one sensor reading (tuser 0) or rezero request (tuser 1) per cycle and returns
// one result request for each: drive_on, direction, drive_level, the unwrapped angle
// in 1/2^READING_BITS turn and the speed. Sustained rate is one request per clock while
// out_tready stays high; a request passes through the input register, the unwrap
// stage and the drive rule stage, then a 27x20 multiply and saturate into the output register.
// All stages move together whenever the output register is empty or being taken, and
// in_tready is high just then. Configuration writes go through
// cfg_wr_en/cfg_addr/cfg_wr_data and are to be done while no request is in flight.

module haptic_knob_angle_and_force
  import hkaf_pkg::*;
#(
  parameter int READING_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [READING_BITS-1:0] sensor_reading, zero fill above
  input  logic [((READING_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // [0] opcode
  input  logic                  in_tuser,
  // result requests
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] drive_on, [1] direction, [17:2] drive_level, [43:18] angle,
  // [70:44] speed, zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wr_data
);

  localparam int RB    = READING_BITS;
  localparam int MAG_W = RB + 1;
  localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;
  localparam int UNW_W = (TURN_W + RB > ANGLE_W) ? TURN_W + RB : ANGLE_W;
  localparam int EXC_W = SPEED_W;
  localparam int XW    = SPEED_W + 1;
  localparam int PROD_W = EXC_W + GAIN_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  mode_t              mode_r;
  logic [THR_W-1:0]   flip_threshold_r;
  logic [DB_W-1:0]    angle_dead_band_r;
  logic [DB_W-1:0]    speed_dead_band_r;
  logic [SGAIN_W-1:0] spring_gain_r;
  logic [GAIN_W-1:0]  damping_gain_r;
  logic [GAIN_W-1:0]  texture_gain_r;
  logic [ANGLE_W-1:0] wall_position_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= MODE_SPRING;
      flip_threshold_r  <= RST_FLIP_THRESHOLD;
      angle_dead_band_r <= RST_ANGLE_DEAD_BAND;
      speed_dead_band_r <= RST_SPEED_DEAD_BAND;
      spring_gain_r     <= RST_SPRING_GAIN;
      damping_gain_r    <= RST_DAMPING_GAIN;
      texture_gain_r    <= RST_TEXTURE_GAIN;
      wall_position_r   <= RST_WALL_POSITION;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MODE:            mode_r            <= mode_t'(cfg_wr_data[1:0]);
        REG_FLIP_THRESHOLD:  flip_threshold_r  <= cfg_wr_data[THR_W-1:0];
        REG_ANGLE_DEAD_BAND: angle_dead_band_r <= cfg_wr_data[DB_W-1:0];
        REG_SPEED_DEAD_BAND: speed_dead_band_r <= cfg_wr_data[DB_W-1:0];
        REG_SPRING_GAIN:     spring_gain_r     <= cfg_wr_data[SGAIN_W-1:0];
        REG_DAMPING_GAIN:    damping_gain_r    <= cfg_wr_data[GAIN_W-1:0];
        REG_TEXTURE_GAIN:    texture_gain_r    <= cfg_wr_data[GAIN_W-1:0];
        REG_WALL_POSITION:   wall_position_r   <= cfg_wr_data[ANGLE_W-1:0];
        default:             ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: move whenever the output register is free or being taken
  logic out_valid_r;
  logic adv;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // input register
  logic          s0_valid_r;
  logic          s0_rezero_r;
  logic [RB-1:0] s0_reading_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_rezero_r  <= in_tuser;
      s0_reading_r <= in_tdata[RB-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // unwrap state
  logic [RB-1:0]      prev_reading_r, prev_reading_nxt;
  logic [RB-1:0]      prev_prev_reading_r, prev_prev_reading_nxt;
  logic [RB-1:0]      zero_reading_r, zero_reading_nxt;
  logic [TURN_W-1:0]  turn_count_r, turn_count_nxt;
  logic               wrap_latched_r, wrap_latched_nxt;
  logic [ANGLE_W-1:0] angle_reg_r, angle_reg_nxt;

  logic signed [MAG_W-1:0]   diff;
  logic [MAG_W-1:0]          mag;
  logic                      wrap;
  logic [UNW_W-1:0]          unwrapped;
  logic signed [SPEED_W-1:0] speed_nxt;

  // reading jump against two samples back, turn count and angle
  always_comb begin
    diff = $signed({1'b0, s0_reading_r}) - $signed({1'b0, prev_prev_reading_r});
    mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    wrap = (CMP_W'(mag) > CMP_W'(flip_threshold_r)) && !wrap_latched_r;

    turn_count_nxt = turn_count_r;
    if (wrap) begin
      if (!diff[MAG_W-1])
        turn_count_nxt = turn_count_r - TURN_W'(1);
      else
        turn_count_nxt = turn_count_r + TURN_W'(1);
    end

    unwrapped = (UNW_W'($signed(turn_count_nxt)) << RB)
              + UNW_W'(s0_reading_r) - UNW_W'(zero_reading_r);

    prev_reading_nxt      = s0_reading_r;
    prev_prev_reading_nxt = prev_reading_r;
    zero_reading_nxt      = zero_reading_r;
    wrap_latched_nxt      = wrap;
    angle_reg_nxt         = unwrapped[ANGLE_W-1:0];

    // rezero keeps the wrap latch and clears the count and angle
    if (s0_rezero_r) begin
      prev_reading_nxt      = s0_reading_r;
      prev_prev_reading_nxt = s0_reading_r;
      zero_reading_nxt      = s0_reading_r;
      turn_count_nxt        = '0;
      wrap_latched_nxt      = wrap_latched_r;
      angle_reg_nxt         = '0;
    end

    speed_nxt = SPEED_W'($signed(angle_reg_r)) - SPEED_W'($signed(angle_reg_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_reading_r      <= '0;
      prev_prev_reading_r <= '0;
      zero_reading_r      <= '0;
      turn_count_r        <= '0;
      wrap_latched_r      <= 1'b0;
      angle_reg_r         <= '0;
    end else if (adv && s0_valid_r) begin
      prev_reading_r      <= prev_reading_nxt;
      prev_prev_reading_r <= prev_prev_reading_nxt;
      zero_reading_r      <= zero_reading_nxt;
      turn_count_r        <= turn_count_nxt;
      wrap_latched_r      <= wrap_latched_nxt;
      angle_reg_r         <= angle_reg_nxt;
    end
  end

  // angle stage register
  logic                      s1_valid_r;
  logic                      s1_rezero_r;
  logic signed [ANGLE_W-1:0] s1_angle_r;
  logic signed [SPEED_W-1:0] s1_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rezero_r <= s0_rezero_r;
      s1_angle_r  <= $signed(angle_reg_nxt);
      s1_speed_r  <= s0_rezero_r ? '0 : speed_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // drive rule: direction, excess beyond the dead band and gain
  drive_ctl_t            ctl_nxt;
  logic [EXC_W-1:0]      excess_nxt;
  logic [GAIN_W-1:0]     gain_nxt;
  logic signed [XW-1:0]  ang_x, spd_x, adb_x, sdb_x, exc_x;
  logic signed [XW-1:0]  ang3;
  logic [GAIN_W-1:0]     damp_gain;
  logic                  damp_en;

  always_comb begin
    ang_x = XW'(s1_angle_r);
    spd_x = XW'(s1_speed_r);
    adb_x = $signed(XW'(angle_dead_band_r));
    sdb_x = $signed(XW'(speed_dead_band_r));
    ang3  = ang_x + (ang_x <<< 1);

    ctl_nxt   = '0;
    exc_x     = '0;
    gain_nxt  = '0;
    damp_en   = 1'b0;
    damp_gain = damping_gain_r;

    unique case (mode_r)
      MODE_SPRING: begin
        gain_nxt = GAIN_W'(spring_gain_r);
        if (ang_x > adb_x) begin
          ctl_nxt.on = 1'b1;
          exc_x      = ang_x - adb_x;
        end else if (ang_x < -adb_x) begin
          ctl_nxt.on  = 1'b1;
          ctl_nxt.dir = 1'b1;
          exc_x       = -ang_x - adb_x;
        end
      end
      MODE_DAMPER: begin
        damp_en = 1'b1;
      end
      MODE_TEXTURE: begin
        // active on every other third-turn band
        damp_en   = ang3[RB];
        damp_gain = texture_gain_r;
      end
      MODE_WALL: begin
        if (s1_angle_r > $signed(wall_position_r)) begin
          ctl_nxt.on    = 1'b1;
          ctl_nxt.fixed = 1'b1;
        end
      end
      default: ;
    endcase

    // shared damper rule
    if (damp_en) begin
      gain_nxt = damp_gain;
      if (spd_x > sdb_x) begin
        ctl_nxt.on  = 1'b1;
        ctl_nxt.dir = 1'b1;
        exc_x       = spd_x - sdb_x;
      end else if (spd_x < -sdb_x) begin
        ctl_nxt.on = 1'b1;
        exc_x      = -spd_x - sdb_x;
      end
    end

    if (s1_rezero_r)
      ctl_nxt = '0;
    excess_nxt = exc_x[EXC_W-1:0];
  end

  // rule stage register
  logic                      s2_valid_r;
  drive_ctl_t                s2_ctl_r;
  logic [EXC_W-1:0]          s2_excess_r;
  logic [GAIN_W-1:0]         s2_gain_r;
  logic signed [ANGLE_W-1:0] s2_angle_r;
  logic signed [SPEED_W-1:0] s2_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r    <= ctl_nxt;
      s2_excess_r <= excess_nxt;
      s2_gain_r   <= gain_nxt;
      s2_angle_r  <= s1_angle_r;
      s2_speed_r  <= s1_speed_r;
    end
  end

  // ---------------------------------------------------------------------------
  // scale by the gain, drop the fraction, saturate; a fixed drive gives WALL_DRIVE
  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W-1:0] level_nxt;

  always_comb begin
    prod = PROD_W'(s2_excess_r) * PROD_W'(s2_gain_r);
    if (!s2_ctl_r.on)
      level_nxt = '0;
    else if (s2_ctl_r.fixed)
      level_nxt = WALL_DRIVE;
    else if (|prod[PROD_W-1:RB+LEVEL_W])
      level_nxt = '1;
    else
      level_nxt = prod[RB+LEVEL_W-1:RB];
  end

  // output register
  logic                      out_on_r;
  logic                      out_dir_r;
  logic [LEVEL_W-1:0]        out_level_r;
  logic signed [ANGLE_W-1:0] out_angle_r;
  logic signed [SPEED_W-1:0] out_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_on_r    <= s2_ctl_r.on;
      out_dir_r   <= s2_ctl_r.dir;
      out_level_r <= level_nxt;
      out_angle_r <= s2_angle_r;
      out_speed_r <= s2_speed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_speed_r, out_angle_r, out_level_r, out_dir_r, out_on_r});

endmodule
